>>> rtl/core/uvs_pkg.sv
`default_nettype none
package uvs_pkg;

	// Mesh limits and sine quantization
	localparam int unsigned MAX_RINGS       = 64;
	localparam int unsigned SINE_DEPTH_LOG2 = 10;
	localparam int unsigned SINE_DEPTH      = 1 << SINE_DEPTH_LOG2;
	localparam int unsigned SINE_LAT        = 7;
	localparam int unsigned JQ_DEPTH        = 4;

	localparam logic [17:0] QUARTER = 18'h10000;

	// Horner coefficients of sin(pi/2 x), Q30
	localparam logic [30:0] SC0 = 31'd172272;
	localparam logic [30:0] SC1 = 31'd5026995;
	localparam logic [30:0] SC2 = 31'd85569306;
	localparam logic [30:0] SC3 = 31'd693598670;
	localparam logic [30:0] SC4 = 31'd1686629713;

	// Reciprocal of three for operands below 2^19
	localparam logic [17:0] RECIP3 = 18'd174763;

	// Configuration register indexes
	localparam logic [2:0] REG_CENTER_X = 3'd0;
	localparam logic [2:0] REG_CENTER_Y = 3'd1;
	localparam logic [2:0] REG_CENTER_Z = 3'd2;
	localparam logic [2:0] REG_RADIUS   = 3'd3;
	localparam logic [2:0] REG_RINGS    = 3'd4;
	localparam logic [2:0] REG_STEP     = 3'd5;

	typedef struct packed {
		logic       mode;
		logic [7:0] ring;
		logic [7:0] segment;
	} req_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               is_centroid;
		logic [2:0]         corner_count;
		logic               last;
		logic               bad_request;
	} res_t;

	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic [30:0]        radius;
		logic [6:0]         rpq;
		logic [16:0]        step;
	} cfg_t;

	typedef enum logic [1:0] {
		KIND_VERT   = 2'd0,
		KIND_CORNER = 2'd1,
		KIND_CENT   = 2'd2,
		KIND_BAD    = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [2:0] cnt;
		logic       last;
		logic       first;
	} tag_t;

	typedef struct packed {
		logic [7:0] ring;
		logic [7:0] seg;
		logic       pole_s;
		logic       pole_n;
	} corner_t;

	typedef struct packed {
		logic             bad;
		logic             face;
		logic [2:0]       cnt;
		corner_t [3:0]    corner;
	} job_t;

	typedef struct packed {
		corner_t pt;
		tag_t    tag;
	} vreq_t;

	// (a * b) >> 30 on Q30 operands
	function automatic logic [31:0] mulsh30(input logic [30:0] a, input logic [30:0] b);
		logic [61:0] p;
		p = 62'(a) * 62'(b);
		return p[61:30];
	endfunction

	// v / 2^16 rounded to nearest, ties away from zero
	function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
		logic [63:0] mag;
		logic [63:0] r;
		mag = v[63] ? 64'(-v) : 64'(v);
		r   = (mag + 64'd32768) >> 16;
		return v[63] ? -$signed(r) : $signed(r);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		else if (v < -64'sd2147483648)
			return 32'sh80000000;
		else
			return $signed(v[31:0]);
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/uv_sphere_mesh_generator_top.sv
`default_nettype none
// Channel  | Handshake        | Payload
// ---------+------------------+----------------------------------------
// request  | push / full      | req  (mode, ring, segment)
// result   | pop / empty      | res  (x, y, z, flags, corner_count)
// config   | cfg_we           | cfg_idx, cfg_wdata (32 bits)
//
// A vertex request or a bad request gives one result, a face request 4 or 5,
// one per cycle while the result queue has room. Requests enter a 4-deep job
// queue; each result passes the phase stage, the 7-stage sine pipeline and
// the scaling and mean stages before it is written to the result queue.
// The sequencer issues only while the result queue has room for all work
// in flight, so stalls on the result side back up to full without loss.
// arst_n clears all control state and loads the register reset values.
module uv_sphere_mesh_generator_top #(
	parameter int unsigned OUT_DEPTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [2:0]    cfg_idx,
	input  logic [31:0]   cfg_wdata,
	input  logic          push,
	input  uvs_pkg::req_t req,
	output logic          full,
	output logic          empty,
	input  logic          pop,
	output uvs_pkg::res_t res
);
	uvs_pkg::cfg_t   cfg_q;
	logic            job_valid, job_pop;
	uvs_pkg::job_t   job;
	logic            vreq_valid, vout_valid;
	uvs_pkg::vreq_t  vreq;
	uvs_pkg::tag_t   vout_tag;
	logic signed [31:0] vout_x, vout_y, vout_z;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cx     <= '0;
			cfg_q.cy     <= '0;
			cfg_q.cz     <= '0;
			cfg_q.radius <= 31'd65536;
			cfg_q.rpq    <= 7'd4;
			cfg_q.step   <= 17'd16384;
		end else if (cfg_we) begin
			case (cfg_idx)
				uvs_pkg::REG_CENTER_X: cfg_q.cx     <= $signed(cfg_wdata);
				uvs_pkg::REG_CENTER_Y: cfg_q.cy     <= $signed(cfg_wdata);
				uvs_pkg::REG_CENTER_Z: cfg_q.cz     <= $signed(cfg_wdata);
				uvs_pkg::REG_RADIUS:   cfg_q.radius <= cfg_wdata[30:0];
				uvs_pkg::REG_RINGS:    cfg_q.rpq    <= cfg_wdata[6:0];
				uvs_pkg::REG_STEP:     cfg_q.step   <= cfg_wdata[16:0];
				default: ;
			endcase
		end
	end

	uvs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.req       (req),
		.full      (full),
		.job_valid (job_valid),
		.job       (job),
		.job_pop   (job_pop)
	);

	uvs_vertex u_vertex (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (vreq_valid),
		.in_req    (vreq),
		.out_valid (vout_valid),
		.out_tag   (vout_tag),
		.out_x     (vout_x),
		.out_y     (vout_y),
		.out_z     (vout_z)
	);

	uvs_back #(.OUT_DEPTH(OUT_DEPTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.job_valid  (job_valid),
		.job        (job),
		.job_pop    (job_pop),
		.vreq_valid (vreq_valid),
		.vreq       (vreq),
		.vout_valid (vout_valid),
		.vout_tag   (vout_tag),
		.vout_x     (vout_x),
		.vout_y     (vout_y),
		.vout_z     (vout_z),
		.empty      (empty),
		.pop        (pop),
		.res        (res)
	);

endmodule
`default_nettype wire

>>> rtl/core/uvs_sine.sv
`default_nettype none
module uvs_sine (
	input  logic               clk,
	input  logic [17:0]        phase,
	output logic signed [17:0] sine
);
	localparam int unsigned SH = 16 - uvs_pkg::SINE_DEPTH_LOG2;
	localparam int unsigned KW = uvs_pkg::SINE_DEPTH_LOG2 + 1;

	logic [16:0]   f_rnd;
	logic [KW-1:0] k_raw;
	logic [KW-1:0] k;
	logic [30:0]   x_s1, x_s2, x_s3, x_s4, x_s5, x_s6;
	logic [30:0]   x2_s2, x2_s3, x2_s4, x2_s5;
	logic [30:0]   t_s3, t_s4, t_s5, t_s6;
	logic          neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [31:0]   s_full;
	logic [32:0]   s_rnd;
	logic [17:0]   s_cap;

	// Quadrant fold and table index
	assign f_rnd = {1'b0, phase[15:0]} + 17'(1 << (SH - 1));
	assign k_raw = KW'(f_rnd >> SH);
	assign k     = phase[16] ? KW'(uvs_pkg::SINE_DEPTH) - k_raw : k_raw;

	// Final product, rounding to signed Q2.16 and cap
	assign s_full = uvs_pkg::mulsh30(x_s6, t_s6);
	assign s_rnd  = ({1'b0, s_full} + 33'd8192) >> 14;
	assign s_cap  = (s_rnd > 33'd65536) ? 18'd65536 : s_rnd[17:0];

	// Horner pipeline, at most one multiply per stage
	always_ff @(posedge clk) begin
		x_s1   <= 31'(k) << (30 - uvs_pkg::SINE_DEPTH_LOG2);
		neg_s1 <= phase[17];

		x_s2   <= x_s1;
		x2_s2  <= 31'(uvs_pkg::mulsh30(x_s1, x_s1));
		neg_s2 <= neg_s1;

		x_s3   <= x_s2;
		x2_s3  <= x2_s2;
		t_s3   <= uvs_pkg::SC1 - 31'(uvs_pkg::mulsh30(x2_s2, uvs_pkg::SC0));
		neg_s3 <= neg_s2;

		x_s4   <= x_s3;
		x2_s4  <= x2_s3;
		t_s4   <= uvs_pkg::SC2 - 31'(uvs_pkg::mulsh30(x2_s3, t_s3));
		neg_s4 <= neg_s3;

		x_s5   <= x_s4;
		x2_s5  <= x2_s4;
		t_s5   <= uvs_pkg::SC3 - 31'(uvs_pkg::mulsh30(x2_s4, t_s4));
		neg_s5 <= neg_s4;

		x_s6   <= x_s5;
		t_s6   <= uvs_pkg::SC4 - 31'(uvs_pkg::mulsh30(x2_s5, t_s5));
		neg_s6 <= neg_s5;

		sine   <= neg_s6 ? -$signed(s_cap) : $signed(s_cap);
	end

endmodule
`default_nettype wire

>>> rtl/core/uvs_vertex.sv
`default_nettype none
module uvs_vertex (
	input  logic                clk,
	input  logic                arst_n,
	input  uvs_pkg::cfg_t       cfg,
	input  logic                in_valid,
	input  uvs_pkg::vreq_t      in_req,
	output logic                out_valid,
	output uvs_pkg::tag_t       out_tag,
	output logic signed [31:0]  out_x,
	output logic signed [31:0]  out_y,
	output logic signed [31:0]  out_z
);
	localparam int unsigned LAT = uvs_pkg::SINE_LAT;

	logic [24:0]         ring_ph, seg_ph;
	logic [17:0]         pp_s1, yp_s1;
	logic                v_s1;
	uvs_pkg::vreq_t      rq_s1;
	logic                v_d [LAT];
	uvs_pkg::vreq_t      rq_d [LAT];
	logic signed [17:0]  cos_p, sin_p, cos_y, sin_y;
	logic signed [35:0]  pxy_x, pxy_y;
	logic signed [49:0]  pz;
	logic signed [31:0]  rad_s;
	logic signed [17:0]  a_s9, b_s9;
	logic signed [33:0]  c_s9;
	logic                v_s9, v_s10;
	uvs_pkg::vreq_t      rq_s9, rq_s10;
	logic signed [49:0]  px, py;
	logic signed [33:0]  xo_s10, yo_s10, zo_s10;
	logic signed [63:0]  xs, ys, zs;

	assign rad_s   = $signed({1'b0, cfg.radius});
	assign ring_ph = in_req.pt.ring * cfg.step;
	assign seg_ph  = in_req.pt.seg * cfg.step;

	// Phase stage
	always_ff @(posedge clk) begin
		pp_s1 <= ring_ph[17:0] - uvs_pkg::QUARTER;
		yp_s1 <= seg_ph[17:0];
		rq_s1 <= in_req;
	end

	uvs_sine u_cos_p (.clk(clk), .phase(pp_s1 + uvs_pkg::QUARTER), .sine(cos_p));
	uvs_sine u_sin_p (.clk(clk), .phase(pp_s1),                    .sine(sin_p));
	uvs_sine u_cos_y (.clk(clk), .phase(yp_s1 + uvs_pkg::QUARTER), .sine(cos_y));
	uvs_sine u_sin_y (.clk(clk), .phase(yp_s1),                    .sine(sin_y));

	// Request tag follows the sine latency
	always_ff @(posedge clk) begin
		rq_d[0] <= rq_s1;
		for (int i = 1; i < LAT; i++)
			rq_d[i] <= rq_d[i-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < LAT; i++)
				v_d[i] <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_d[0] <= v_s1;
			for (int i = 1; i < LAT; i++)
				v_d[i] <= v_d[i-1];
			v_s9  <= v_d[LAT-1];
			v_s10 <= v_s9;
			out_valid <= v_s10;
		end
	end

	// Trig products
	assign pxy_x = cos_y * cos_p;
	assign pxy_y = sin_y * cos_p;
	assign pz    = sin_p * rad_s;

	always_ff @(posedge clk) begin
		a_s9  <= 18'(uvs_pkg::rnd16(64'(pxy_x)));
		b_s9  <= 18'(uvs_pkg::rnd16(64'(pxy_y)));
		c_s9  <= 34'(uvs_pkg::rnd16(64'(pz)));
		rq_s9 <= rq_d[LAT-1];
	end

	// Radius scaling
	assign px = a_s9 * rad_s;
	assign py = b_s9 * rad_s;

	always_ff @(posedge clk) begin
		xo_s10 <= 34'(uvs_pkg::rnd16(64'(px)));
		yo_s10 <= 34'(uvs_pkg::rnd16(64'(py)));
		zo_s10 <= c_s9;
		rq_s10 <= rq_s9;
	end

	// Center offset, poles forced
	always_comb begin
		xs = 64'(xo_s10) + 64'(cfg.cx);
		ys = 64'(yo_s10) + 64'(cfg.cy);
		zs = 64'(zo_s10) + 64'(cfg.cz);
		if (rq_s10.pt.pole_s || rq_s10.pt.pole_n) begin
			xs = 64'(cfg.cx);
			ys = 64'(cfg.cy);
			zs = rq_s10.pt.pole_s ? 64'(cfg.cz) - 64'(rad_s) : 64'(cfg.cz) + 64'(rad_s);
		end
	end

	always_ff @(posedge clk) begin
		out_x   <= uvs_pkg::sat32(xs);
		out_y   <= uvs_pkg::sat32(ys);
		out_z   <= uvs_pkg::sat32(zs);
		out_tag <= rq_s10.tag;
	end

endmodule
`default_nettype wire

>>> rtl/core/uvs_front.sv
`default_nettype none
module uvs_front (
	input  logic            clk,
	input  logic            arst_n,
	input  uvs_pkg::cfg_t   cfg,
	input  logic            push,
	input  uvs_pkg::req_t   req,
	output logic            full,
	output logic            job_valid,
	output uvs_pkg::job_t   job,
	input  logic            job_pop
);
	localparam int unsigned DEPTH = uvs_pkg::JQ_DEPTH;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(DEPTH + 1);

	logic [6:0]    n;
	logic [7:0]    twon;
	logic [8:0]    segs;
	logic [8:0]    seg_inc;
	logic [7:0]    s1;
	logic          bad;
	uvs_pkg::job_t cls;
	uvs_pkg::job_t jq_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          wr, rd;

	// Mesh bounds
	assign n       = (cfg.rpq > 7'(uvs_pkg::MAX_RINGS)) ? 7'(uvs_pkg::MAX_RINGS) : cfg.rpq;
	assign twon    = {n, 1'b0};
	assign segs    = {n, 2'b00};
	assign seg_inc = {1'b0, req.segment} + 9'd1;
	assign s1      = (seg_inc == segs) ? 8'd0 : seg_inc[7:0];
	assign bad     = (n == 7'd0) || ({1'b0, req.segment} >= segs) ||
			(req.mode ? (req.ring >= twon) : (req.ring > twon));

	// Classify and lay out the corner list
	always_comb begin
		cls        = '0;
		cls.bad    = bad;
		cls.face   = req.mode && !bad;
		cls.cnt    = 3'd1;
		cls.corner[0] = '{ring: req.ring, seg: req.segment,
			pole_s: (req.ring == 8'd0), pole_n: (req.ring == twon)};
		if (req.mode) begin
			if (req.ring == 8'd0) begin
				cls.cnt       = 3'd3;
				cls.corner[0] = '{ring: 8'd0, seg: 8'd0, pole_s: 1'b1, pole_n: 1'b0};
				cls.corner[1] = '{ring: 8'd1, seg: s1, pole_s: 1'b0, pole_n: 1'b0};
				cls.corner[2] = '{ring: 8'd1, seg: req.segment, pole_s: 1'b0, pole_n: 1'b0};
			end else if (req.ring == twon - 8'd1) begin
				cls.cnt       = 3'd3;
				cls.corner[0] = '{ring: req.ring, seg: req.segment, pole_s: 1'b0, pole_n: 1'b0};
				cls.corner[1] = '{ring: req.ring, seg: s1, pole_s: 1'b0, pole_n: 1'b0};
				cls.corner[2] = '{ring: twon, seg: 8'd0, pole_s: 1'b0, pole_n: 1'b1};
			end else begin
				cls.cnt       = 3'd4;
				cls.corner[0] = '{ring: req.ring, seg: req.segment, pole_s: 1'b0, pole_n: 1'b0};
				cls.corner[1] = '{ring: req.ring, seg: s1, pole_s: 1'b0, pole_n: 1'b0};
				cls.corner[2] = '{ring: req.ring + 8'd1, seg: req.segment,
					pole_s: 1'b0, pole_n: 1'b0};
				cls.corner[3] = '{ring: req.ring + 8'd1, seg: s1, pole_s: 1'b0, pole_n: 1'b0};
			end
			if (bad)
				cls.cnt = 3'd1;
		end
	end

	// Job queue
	assign full      = (cnt_q == CW'(DEPTH));
	assign job_valid = (cnt_q != '0);
	assign job       = jq_q[rp_q];
	assign wr        = push && !full;
	assign rd        = job_pop && job_valid;

	always_ff @(posedge clk) begin
		if (wr)
			jq_q[wp_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (rd)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + CW'(wr) - CW'(rd);
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/uvs_back.sv
`default_nettype none
module uvs_back #(
	parameter int unsigned OUT_DEPTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  uvs_pkg::cfg_t       cfg,
	input  logic                job_valid,
	input  uvs_pkg::job_t       job,
	output logic                job_pop,
	output logic                vreq_valid,
	output uvs_pkg::vreq_t      vreq,
	input  logic                vout_valid,
	input  uvs_pkg::tag_t       vout_tag,
	input  logic signed [31:0]  vout_x,
	input  logic signed [31:0]  vout_y,
	input  logic signed [31:0]  vout_z,
	output logic                empty,
	input  logic                pop,
	output uvs_pkg::res_t       res
);
	localparam int unsigned AW = $clog2(OUT_DEPTH);
	localparam int unsigned CW = $clog2(OUT_DEPTH + 1);

	logic [2:0]          idx_q;
	logic                last_tok;
	logic                credit_ok;
	logic [CW:0]         used;
	logic [CW-1:0]       inflight_q, fifo_cnt_q;
	logic [AW-1:0]       wp_q, rp_q;
	uvs_pkg::res_t       mem [OUT_DEPTH];
	logic                wr, rd;

	logic signed [31:0]  vin [3];
	logic signed [31:0]  cen [3];
	logic signed [34:0]  acc_q [3];
	logic [34:0]         acc_mag [3];

	logic                v_s1, v_s2;
	uvs_pkg::tag_t       tag_s1, tag_s2;
	logic signed [31:0]  val_s1 [3];
	logic signed [31:0]  val_s2 [3];
	logic [33:0]         m1_s1 [3];
	logic                neg_s1 [3];
	logic                neg_s2 [3];
	logic [34:0]         ph [3];
	logic [14:0]         qh_s2 [3];
	logic [1:0]          rh_s2 [3];
	logic [16:0]         ml_s2 [3];
	logic [31:0]         q4_s2 [3];
	logic [36:0]         pl [3];
	logic [32:0]         q3 [3];
	logic [32:0]         qm [3];
	logic signed [63:0]  mean [3];
	logic signed [31:0]  outv [3];
	uvs_pkg::res_t       wres;

	// Token sequencer
	assign last_tok   = !job.face || (idx_q == job.cnt);
	assign used       = {1'b0, inflight_q} + {1'b0, fifo_cnt_q};
	assign credit_ok  = (used < (CW+1)'(OUT_DEPTH));
	assign vreq_valid = job_valid && credit_ok;
	assign job_pop    = vreq_valid && last_tok;

	always_comb begin
		vreq           = '0;
		vreq.pt        = job.corner[idx_q[1:0]];
		vreq.tag.cnt   = job.cnt;
		vreq.tag.last  = last_tok;
		vreq.tag.first = (idx_q == 3'd0);
		if (job.bad)
			vreq.tag.kind = uvs_pkg::KIND_BAD;
		else if (!job.face)
			vreq.tag.kind = uvs_pkg::KIND_VERT;
		else if (last_tok)
			vreq.tag.kind = uvs_pkg::KIND_CENT;
		else
			vreq.tag.kind = uvs_pkg::KIND_CORNER;
		if (idx_q == 3'd4)
			vreq.pt = job.corner[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= '0;
		else if (vreq_valid)
			idx_q <= last_tok ? 3'd0 : idx_q + 3'd1;
	end

	assign vin[0] = vout_x;
	assign vin[1] = vout_y;
	assign vin[2] = vout_z;
	assign cen[0] = cfg.cx;
	assign cen[1] = cfg.cy;
	assign cen[2] = cfg.cz;

	// Corner sums
	always_ff @(posedge clk) begin
		if (vout_valid && vout_tag.kind == uvs_pkg::KIND_CORNER) begin
			for (int a = 0; a < 3; a++)
				acc_q[a] <= (vout_tag.first ? 35'sd0 : acc_q[a]) + 35'(vin[a]);
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++)
			acc_mag[a] = acc_q[a][34] ? 35'(-acc_q[a]) : 35'(acc_q[a]);
	end

	// Stage 1: mean numerator or pass-through
	always_ff @(posedge clk) begin
		tag_s1 <= vout_tag;
		for (int a = 0; a < 3; a++) begin
			val_s1[a] <= (vout_tag.kind == uvs_pkg::KIND_BAD) ? 32'sd0 : vin[a];
			neg_s1[a] <= acc_q[a][34];
			m1_s1[a]  <= acc_mag[a][33:0] + ((vout_tag.cnt == 3'd4) ? 34'd2 : 34'd1);
		end
	end

	// Stage 2: high part of divide by three
	always_comb begin
		for (int a = 0; a < 3; a++)
			ph[a] = m1_s1[a][33:17] * uvs_pkg::RECIP3;
	end

	always_ff @(posedge clk) begin
		tag_s2 <= tag_s1;
		for (int a = 0; a < 3; a++) begin
			val_s2[a] <= val_s1[a];
			neg_s2[a] <= neg_s1[a];
			qh_s2[a]  <= ph[a][33:19];
			rh_s2[a]  <= 2'(m1_s1[a][33:17] - 17'(ph[a][33:19]) * 17'd3);
			ml_s2[a]  <= m1_s1[a][16:0];
			q4_s2[a]  <= m1_s1[a][33:2];
		end
	end

	// Low part, sign and center removal
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			pl[a]   = {rh_s2[a], ml_s2[a]} * uvs_pkg::RECIP3;
			q3[a]   = {1'b0, qh_s2[a], 17'd0} + 33'(pl[a][36:19]);
			qm[a]   = (tag_s2.cnt == 3'd4) ? {1'b0, q4_s2[a]} : q3[a];
			mean[a] = neg_s2[a] ? -$signed(64'(qm[a])) : $signed(64'(qm[a]));
			outv[a] = (tag_s2.kind == uvs_pkg::KIND_CENT) ?
				uvs_pkg::sat32(mean[a] - 64'(cen[a])) : val_s2[a];
		end
		wres.x            = outv[0];
		wres.y            = outv[1];
		wres.z            = outv[2];
		wres.is_centroid  = (tag_s2.kind == uvs_pkg::KIND_CENT);
		wres.corner_count = tag_s2.cnt;
		wres.last         = tag_s2.last;
		wres.bad_request  = (tag_s2.kind == uvs_pkg::KIND_BAD);
	end

	// Result queue
	assign wr    = v_s2;
	assign rd    = pop && !empty;
	assign empty = (fifo_cnt_q == '0);
	assign res   = mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem[wp_q] <= wres;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			wp_q       <= '0;
			rp_q       <= '0;
			fifo_cnt_q <= '0;
			inflight_q <= '0;
		end else begin
			v_s1 <= vout_valid;
			v_s2 <= v_s1;
			if (wr)
				wp_q <= (wp_q == AW'(OUT_DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (rd)
				rp_q <= (rp_q == AW'(OUT_DEPTH - 1)) ? '0 : rp_q + AW'(1);
			fifo_cnt_q <= fifo_cnt_q + CW'(wr) - CW'(rd);
			inflight_q <= inflight_q + CW'(vreq_valid) - CW'(wr);
		end
	end

`ifndef NO_ASSERTIONS
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used <= (CW+1)'(OUT_DEPTH))
		else $error("results in flight exceed queue space");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> (fifo_cnt_q != CW'(OUT_DEPTH)) || rd)
		else $error("result queue written while full");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> (idx_q <= job.cnt))
		else $error("token index past corner count");
	a_inflight_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(inflight_q == '0) |-> !v_s2)
		else $error("result written with nothing in flight");
`endif

endmodule
`default_nettype wire
